@@ rtl/plist_pkg.sv @@
// Shared types and codes for the positional list block.
package plist_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned VAL_W = 32;

  // Request codes carried on the operation port.
  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  // Result status codes.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Read value returned by every request that is not a valid get.
  localparam logic signed [VAL_W-1:0] NO_VALUE = '1;

  // Job handed from the request checker to the sequencer.
  typedef struct packed {
    logic go;
    op_t  op;
    logic shift;
  } job_t;

  // Sequencer status back to the top level.
  typedef struct packed {
    logic busy;
    logic fin;
    logic got;
  } seq_stat_t;

  // Memory port strobes from the sequencer.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

@@ rtl/plist_store.sv @@
// Element memory: one write port and one registered read port.
module plist_store
  import plist_pkg::*;
#(
  parameter int unsigned DEPTH = CAPACITY_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  mem_ctl_t                mctl,
  input  logic [AW-1:0]           raddr,
  input  logic [AW-1:0]           waddr,
  input  logic signed [VAL_W-1:0] wdata,
  output logic signed [VAL_W-1:0] rdata
);

  logic signed [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/plist_ctrl.sv @@
// Sequencer that walks the element memory one entry a cycle.
module plist_ctrl
  import plist_pkg::*;
#(
  parameter int unsigned DEPTH = CAPACITY_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  job_t                    job,
  input  logic [AW-1:0]           pos,
  input  logic [AW-1:0]           first,
  input  logic [AW-1:0]           stop,
  input  logic [AW-1:0]           tgt0,
  input  logic signed [VAL_W-1:0] val,
  input  logic signed [VAL_W-1:0] rdata,
  output seq_stat_t               stat,
  output mem_ctl_t                mctl,
  output logic [AW-1:0]           raddr,
  output logic [AW-1:0]           waddr,
  output logic signed [VAL_W-1:0] wdata
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SHIFT = 6'b000010,
    S_DRAIN = 6'b000100,
    S_PUT   = 6'b001000,
    S_READ  = 6'b010000,
    S_FIN   = 6'b100000
  } seq_state_t;

  seq_state_t              state, state_next;
  op_t                     op;
  logic [AW-1:0]           pos_r, stop_r;
  logic [AW-1:0]           addr, wtgt, wq;
  logic                    pend;
  logic signed [VAL_W-1:0] val_r;
  logic [AW-1:0]           step;

  // Shared step unit: walk down for an insert, up for a remove.
  assign step = (op == OP_INSERT) ? addr - AW'(1) : addr + AW'(1);

  always_comb begin
    state_next = state;
    mctl       = '0;
    raddr      = addr;
    waddr      = wq;
    wdata      = rdata;
    unique case (state)
      S_IDLE: begin
        if (job.go) begin
          unique case (job.op)
            OP_GET:    state_next = S_READ;
            OP_INSERT: state_next = job.shift ? S_SHIFT : S_PUT;
            default:   state_next = job.shift ? S_SHIFT : S_FIN;
          endcase
        end
      end
      S_SHIFT: begin
        mctl.rd_en = 1'b1;
        mctl.wr_en = pend;
        if (addr == stop_r) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        mctl.wr_en = 1'b1;
        state_next = (op == OP_INSERT) ? S_PUT : S_FIN;
      end
      S_PUT: begin
        mctl.wr_en = 1'b1;
        waddr      = pos_r;
        wdata      = val_r;
        state_next = S_FIN;
      end
      S_READ: begin
        mctl.rd_en = 1'b1;
        raddr      = pos_r;
        state_next = S_FIN;
      end
      S_FIN: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        pend <= 1'b0;
      end else if (state == S_SHIFT) begin
        pend <= 1'b1;
      end
    end
  end

  // Latch the job and advance the walk pointers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && job.go) begin
      op     <= job.op;
      pos_r  <= pos;
      stop_r <= stop;
      val_r  <= val;
      addr   <= first;
      wtgt   <= tgt0;
    end else if (state == S_SHIFT) begin
      wq   <= wtgt;
      wtgt <= addr;
      addr <= step;
    end
  end

  assign stat.busy = (state != S_IDLE);
  assign stat.fin  = (state == S_FIN);
  assign stat.got  = (state == S_FIN) && (op == OP_GET);

  a_no_collide: assert property (@(posedge clk) disable iff (rst)
    (mctl.rd_en && mctl.wr_en) |-> (raddr != waddr))
    else $error("read and write hit the same entry");

  a_fin_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> (state == S_IDLE))
    else $error("finish state held longer than one cycle");

endmodule

@@ rtl/positional_list_insert_remove_get.sv @@
// Top level of the bounded positional list: request check, count and result.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+-----------------------------------
//   request   | start in, busy out         | operation, position, value
//   result    | done out (one cycle)       | status, read_value, element_count
//
// A rejected request (bad position, full list, unused code) gives its result
// the cycle after acceptance and never raises busy. A get reads its entry.
// An insert at position p moves each entry from the top down to p up by one,
// then writes the value at p; a remove moves each entry from p + 1 up to the
// top down by one. The single memory port pair moves one entry per cycle.
// The result strobe follows the last busy cycle. Reset clears the count and
// the sequencer; memory needs no clearing. The receiver cannot stall a result.
module positional_list_insert_remove_get
  import plist_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              operation,
  input  logic [4:0]              position,
  input  logic signed [VAL_W-1:0] value,
  output logic                    done,
  output logic [1:0]              status,
  output logic signed [VAL_W-1:0] read_value,
  output logic [4:0]              element_count
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = (CW > 5) ? CW : 5;

  logic [CW-1:0]           count;
  logic                    accept, launch;
  logic [KW-1:0]           pos_x, cnt_x;
  logic                    get_ok, ins_ok, rem_ok, ins_rng, full;
  logic [AW-1:0]           pos_a, pos_p1, cnt_a, cnt_m1;
  job_t                    job;
  seq_stat_t               stat;
  mem_ctl_t                mctl;
  logic [AW-1:0]           first, stop, tgt0, raddr, waddr;
  logic signed [VAL_W-1:0] wdata, rdata;

  assign accept = start && !busy;
  assign busy   = stat.busy;

  // Range and capacity checks on the raw request.
  assign pos_x   = KW'(position);
  assign cnt_x   = KW'(count);
  assign full    = (count == CW'(CAPACITY));
  assign ins_rng = (pos_x > cnt_x);
  assign get_ok  = (operation == OP_GET) && (pos_x < cnt_x);
  assign ins_ok  = (operation == OP_INSERT) && !ins_rng && !full;
  assign rem_ok  = (operation == OP_REMOVE) && (pos_x < cnt_x);
  assign launch  = accept && (get_ok || ins_ok || rem_ok);

  // Walk bounds: an insert reads from the top down to the position,
  // a remove reads from just above the position up to the top.
  assign pos_a  = AW'(position);
  assign pos_p1 = pos_a + AW'(1);
  assign cnt_a  = AW'(count);
  assign cnt_m1 = AW'(count - CW'(1));

  always_comb begin
    job.go    = launch;
    job.op    = op_t'(operation);
    job.shift = 1'b0;
    first     = pos_p1;
    stop      = cnt_m1;
    tgt0      = pos_a;
    if (operation == OP_INSERT) begin
      job.shift = (pos_x != cnt_x);
      first     = cnt_m1;
      stop      = pos_a;
      tgt0      = cnt_a;
    end else if (operation == OP_REMOVE) begin
      job.shift = ((pos_x + KW'(1)) != cnt_x);
    end
  end

  plist_ctrl #(
    .DEPTH (CAPACITY)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .job   (job),
    .pos   (pos_a),
    .first (first),
    .stop  (stop),
    .tgt0  (tgt0),
    .val   (value),
    .rdata (rdata),
    .stat  (stat),
    .mctl  (mctl),
    .raddr (raddr),
    .waddr (waddr),
    .wdata (wdata)
  );

  plist_store #(
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .mctl  (mctl),
    .raddr (raddr),
    .waddr (waddr),
    .wdata (wdata),
    .rdata (rdata)
  );

  // Update the count as soon as a changing request is accepted; the walk
  // that follows never looks at it.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (launch && ins_ok) begin
      count <= count + CW'(1);
    end else if (launch && rem_ok) begin
      count <= count - CW'(1);
    end
  end

  // Result strobe: drop a rejected transaction straight through, otherwise
  // wait for the sequencer to finish.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && !launch) || stat.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !launch) begin
      status        <= ((operation == OP_INSERT) && !ins_rng) ? ST_FULL : ST_RANGE;
      read_value    <= NO_VALUE;
      element_count <= 5'(count);
    end else if (stat.fin) begin
      status        <= ST_DONE;
      read_value    <= stat.got ? rdata : NO_VALUE;
      element_count <= 5'(count);
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a request is still at work");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("element count beyond capacity");

endmodule
